FILE: rtl/tss_pkg.sv
// Shared types and constants for the two-stacks-in-one-memory block.
// Used by tss_ctrl, tss_dpath and two_stacks_shared_memory.
package tss_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_ONE = 3'd0,
    REQ_PUSH_TWO = 3'd1,
    REQ_POP_ONE  = 3'd2,
    REQ_POP_TWO  = 3'd3,
    REQ_PEEK_ONE = 3'd4,
    REQ_PEEK_TWO = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } stat_code_t;

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [DW-1:0] push_value;
  } tss_in_t;

  typedef struct packed {
    logic signed [DW-1:0] read_data;
    logic [1:0]           status;
    logic                 is_full;
    logic                 first_empty;
    logic                 second_empty;
    logic [CW-1:0]        used_total;
  } tss_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } tss_cmd_t;

endpackage

FILE: rtl/tss_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/tss_ctrl.sv
// Controller for the two-stack block: accept, execute, respond sequence.
// Depends on tss_pkg.
module tss_ctrl import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output tss_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   exec_r;
  logic   resp_r;
  logic   load;

  assign load     = start && !busy_r;
  assign busy     = busy_r;
  assign cmd.load = load;
  assign cmd.exec = exec_r;
  assign cmd.resp = resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      exec_r  <= 1'b0;
      resp_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (load) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
            exec_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= S_RESP;
          exec_r  <= 1'b0;
          resp_r  <= 1'b1;
        end
        S_RESP: begin
          state_r <= S_IDLE;
          resp_r  <= 1'b0;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
          exec_r  <= 1'b0;
          resp_r  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/tss_dpath.sv
// Datapath for the two-stack block: stack counts, capacity, word memory, result.
// Depends on tss_pkg and tss_ram.
module tss_dpath import tss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  tss_cmd_t      cmd,
  input  tss_in_t       in_item,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  output tss_out_t      out_item
);

  logic [2:0]    req_r;
  logic [DW-1:0] val_r;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] second_r, second_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          hit_r, hit_nxt;
  logic [CW-1:0] used_pre;
  logic [CW-1:0] used_post;
  logic          full_pre;
  logic          ram_we;
  logic [CW-1:0] addr_w;
  logic [DW-1:0] ram_rdata;

  assign used_pre = first_r + second_r;
  assign full_pre = used_pre >= cap_r;

  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    stat_nxt   = ST_OK;
    hit_nxt    = 1'b0;
    ram_we     = 1'b0;
    addr_w     = '0;
    case (req_r)
      REQ_PUSH_ONE: begin
        addr_w = first_r;
        if (full_pre) begin
          stat_nxt = ST_OVERFLOW;
        end else begin
          ram_we    = cmd.exec;
          first_nxt = first_r + CW'(1);
        end
      end
      REQ_PUSH_TWO: begin
        addr_w = cap_r - CW'(1) - second_r;
        if (full_pre) begin
          stat_nxt = ST_OVERFLOW;
        end else begin
          ram_we     = cmd.exec;
          second_nxt = second_r + CW'(1);
        end
      end
      REQ_POP_ONE, REQ_PEEK_ONE: begin
        addr_w = first_r - CW'(1);
        if (first_r == '0) begin
          stat_nxt = ST_UNDERFLOW;
        end else begin
          hit_nxt = 1'b1;
          if (req_r == REQ_POP_ONE) begin
            first_nxt = first_r - CW'(1);
          end
        end
      end
      REQ_POP_TWO, REQ_PEEK_TWO: begin
        addr_w = cap_r - second_r;
        if (second_r == '0) begin
          stat_nxt = ST_UNDERFLOW;
        end else begin
          hit_nxt = 1'b1;
          if (req_r == REQ_POP_TWO) begin
            second_nxt = second_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // out-of-range writes saturate to 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_nxt = CW'(1);
    end else if (cfg_wdata > CW'(DEPTH)) begin
      cap_nxt = CW'(DEPTH);
    end else begin
      cap_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      cap_r    <= CW'(DEPTH);
    end else if (cfg_we) begin
      first_r  <= '0;
      second_r <= '0;
      cap_r    <= cap_nxt;
    end else if (cmd.exec) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item.req_type;
      val_r <= in_item.push_value;
    end
    if (cmd.exec) begin
      stat_r <= stat_nxt;
      hit_r  <= hit_nxt;
    end
  end

  tss_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr_w[AW-1:0]),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  assign used_post             = first_r + second_r;
  assign out_item.read_data    = hit_r ? ram_rdata : '1;
  assign out_item.status       = stat_r;
  assign out_item.is_full      = used_post >= cap_r;
  assign out_item.first_empty  = first_r == '0;
  assign out_item.second_empty = second_r == '0;
  assign out_item.used_total   = used_post;

endmodule

FILE: rtl/two_stacks_shared_memory.sv
// Top level: two LIFO stacks sharing one word memory.
// Depends on tss_pkg, tss_ctrl, tss_dpath and tss_ram.
//
// Usage:
//   A request (push, pop or peek on stack one or two) is offered on in_item
//   and transfers at a clock edge where start is high and busy is low.
//   Stack one grows up from address 0, stack two down from capacity-1.
//   The result appears on out_item for exactly one cycle with out_valid high,
//   in the RESP state that follows the EXEC state entered at the request
//   edge, and transfers at the edge that ends RESP; it must be taken then.
//   busy stays high through EXEC and RESP, so no new request is taken until
//   the previous result has transferred; the single-port word memory with
//   registered read sets the execute-then-respond sequence.
//   Overflow and underflow leave the stacks unchanged; read_data is all ones
//   for pushes, errors and unknown request codes.
//   Writing cfg_wdata with cfg_we (only while idle) sets the capacity,
//   saturated to 1..256, and empties both stacks.
//   Synchronous reset (rst_n low) empties both stacks and sets capacity to
//   256. The memory itself is not cleared.
module two_stacks_shared_memory import tss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tss_in_t       in_item,
  output logic          out_valid,
  output tss_out_t      out_item,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  tss_cmd_t cmd;

  tss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tss_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  assign out_valid = cmd.resp;

endmodule

FILE: verif/tb_two_stacks_shared_memory.sv
// Self-checking testbench for two_stacks_shared_memory: directed table, then random phases.
// Every result is checked field by field against a built-in two-stack predictor, or a typed row's expectation.
// Depends on tss_pkg and the RTL of two_stacks_shared_memory only.
`timescale 1ns / 1ps

module tb_two_stacks_shared_memory;
  import tss_pkg::*;

  localparam logic [2:0]    REQ_BAD_LO = 3'd6;
  localparam logic [2:0]    REQ_BAD_HI = 3'd7;
  localparam logic [DW-1:0] NO_DATA    = '1;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  tss_in_t       in_item;
  logic          out_valid;
  tss_out_t      out_item;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  two_stacks_shared_memory u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // predicted stack state
  logic [DW-1:0] word_mem [DEPTH];
  int unsigned   lo_cnt;
  int unsigned   hi_cnt;
  int unsigned   cap_words;

  tss_out_t      pending_results[$];
  int            err_cnt;

  typedef struct {
    bit            cfg_row;
    logic [CW-1:0] cap_val;
    tss_in_t       req;
    bit            typed;
    tss_out_t      want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic tss_out_t stack_step(input tss_in_t req);
    tss_out_t res;
    bit       full;
    full          = (lo_cnt + hi_cnt) >= cap_words;
    res           = '0;
    res.read_data = NO_DATA;
    res.status    = ST_OK;
    case (req.req_type)
      REQ_PUSH_ONE: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          word_mem[lo_cnt] = req.push_value;
          lo_cnt++;
        end
      end
      REQ_PUSH_TWO: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          word_mem[cap_words - 1 - hi_cnt] = req.push_value;
          hi_cnt++;
        end
      end
      REQ_POP_ONE, REQ_PEEK_ONE: begin
        if (lo_cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.read_data = word_mem[lo_cnt - 1];
          if (req.req_type == REQ_POP_ONE) lo_cnt--;
        end
      end
      REQ_POP_TWO, REQ_PEEK_TWO: begin
        if (hi_cnt == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.read_data = word_mem[cap_words - hi_cnt];
          if (req.req_type == REQ_POP_TWO) hi_cnt--;
        end
      end
      default: ;
    endcase
    res.is_full      = (lo_cnt + hi_cnt) >= cap_words;
    res.first_empty  = (lo_cnt == 0);
    res.second_empty = (hi_cnt == 0);
    res.used_total   = CW'(lo_cnt + hi_cnt);
    return res;
  endfunction

  function automatic void add_req(input logic [2:0] rq, input logic [DW-1:0] val);
    dir_row_t r;
    r         = '{default: '0};
    r.req     = '{req_type: rq, push_value: val};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic [2:0] rq, input logic [DW-1:0] val,
                                    input tss_out_t want);
    dir_row_t r;
    r         = '{default: '0};
    r.req     = '{req_type: rq, push_value: val};
    r.typed   = 1'b1;
    r.want    = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CW-1:0] v);
    dir_row_t r;
    r         = '{default: '0};
    r.cfg_row = 1'b1;
    r.cap_val = v;
    dir_rows.push_back(r);
  endfunction

  function automatic tss_in_t pick_req(input bit filling);
    tss_in_t     r;
    int unsigned roll;
    roll         = $urandom_range(99);
    r.push_value = $urandom;
    if (roll < 4) begin
      r.req_type = 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
    end else if (filling ? (roll < 90) : (roll < 19)) begin
      r.req_type = $urandom_range(1) ? REQ_PUSH_TWO : REQ_PUSH_ONE;
    end else if ($urandom_range(99) < 75) begin
      r.req_type = $urandom_range(1) ? REQ_POP_TWO : REQ_POP_ONE;
    end else begin
      r.req_type = $urandom_range(1) ? REQ_PEEK_TWO : REQ_PEEK_ONE;
    end
    return r;
  endfunction

  // Called in the step of a rising edge; returns in the step of the transfer edge.
  task automatic send_req(input tss_in_t req, input int idle_pct, input bit typed,
                          input tss_out_t want);
    int       gap;
    tss_out_t got;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      start   <= 1'b0;
      in_item <= tss_in_t'({$urandom, $urandom});
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = stack_step(req);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CW-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (v == 0) cap_words = 1;
    else if (v > DEPTH) cap_words = DEPTH;
    else cap_words = v;
    lo_cnt = 0;
    hi_cnt = 0;
  endtask

  task automatic run_phase(input logic [CW-1:0] cap_val, input int idle_pct,
                           input int n_items);
    bit filling;
    filling = 1'b1;
    write_capacity(cap_val);
    repeat (n_items) begin
      send_req(pick_req(filling), idle_pct, 1'b0, '0);
      if (filling && (lo_cnt + hi_cnt) >= cap_words) filling = 1'b0;
      else if (!filling && (lo_cnt + hi_cnt) == 0) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
    end
  endtask

  always @(posedge clk) begin : chk_results
    tss_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result expected");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
          err_cnt++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          err_cnt++;
        end
        if (out_item.is_full !== want.is_full) begin
          $error("is_full: expected %0b, got %0b", want.is_full, out_item.is_full);
          err_cnt++;
        end
        if (out_item.first_empty !== want.first_empty) begin
          $error("first_empty: expected %0b, got %0b", want.first_empty,
                 out_item.first_empty);
          err_cnt++;
        end
        if (out_item.second_empty !== want.second_empty) begin
          $error("second_empty: expected %0b, got %0b", want.second_empty,
                 out_item.second_empty);
          err_cnt++;
        end
        if (out_item.used_total !== want.used_total) begin
          $error("used_total: expected %0d, got %0d", want.used_total, out_item.used_total);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    err_cnt   = 0;
    lo_cnt    = 0;
    hi_cnt    = 0;
    cap_words = DEPTH;

    // empty stacks, unknown codes, then pushes, peeks and pops at reset capacity
    add_typed(REQ_POP_ONE,  '0, '{NO_DATA, ST_UNDERFLOW, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_POP_TWO,  '0, '{NO_DATA, ST_UNDERFLOW, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_PEEK_ONE, '0, '{NO_DATA, ST_UNDERFLOW, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_PEEK_TWO, '0, '{NO_DATA, ST_UNDERFLOW, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_BAD_LO, 32'h1234_5678, '{NO_DATA, ST_OK, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_BAD_HI, '1, '{NO_DATA, ST_OK, 1'b0, 1'b1, 1'b1, CW'(0)});
    add_typed(REQ_PUSH_ONE, 32'h7FFF_FFFF, '{NO_DATA, ST_OK, 1'b0, 1'b0, 1'b1, CW'(1)});
    add_typed(REQ_PUSH_TWO, 32'h8000_0000, '{NO_DATA, ST_OK, 1'b0, 1'b0, 1'b0, CW'(2)});
    add_req(REQ_PEEK_ONE, '0);
    add_req(REQ_PEEK_TWO, '0);
    add_req(REQ_PUSH_ONE, '0);
    add_req(REQ_PUSH_TWO, '1);
    add_req(REQ_POP_ONE, '0);
    add_req(REQ_POP_ONE, '0);
    add_req(REQ_POP_TWO, '0);
    add_req(REQ_PEEK_TWO, '0);
    // single-word memory
    add_cfg(CW'(1));
    add_typed(REQ_PUSH_TWO, 32'h5555_5555, '{NO_DATA, ST_OK, 1'b1, 1'b1, 1'b0, CW'(1)});
    add_typed(REQ_PUSH_ONE, 32'hAAAA_AAAA, '{NO_DATA, ST_OVERFLOW, 1'b1, 1'b1, 1'b0, CW'(1)});
    add_req(REQ_POP_TWO, '0);
    // zero saturates to one word
    add_cfg(CW'(0));
    add_typed(REQ_PUSH_ONE, 32'hAAAA_AAAA, '{NO_DATA, ST_OK, 1'b1, 1'b0, 1'b1, CW'(1)});
    add_typed(REQ_PUSH_TWO, '0, '{NO_DATA, ST_OVERFLOW, 1'b1, 1'b0, 1'b1, CW'(1)});
    add_req(REQ_PEEK_ONE, '0);
    // above depth saturates to full size
    add_cfg('1);
    add_req(REQ_PUSH_TWO, 32'h0F0F_0F0F);
    add_req(REQ_PEEK_TWO, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_row) write_capacity(dir_rows[i].cap_val);
      else send_req(dir_rows[i].req, 0, dir_rows[i].typed, dir_rows[i].want);
    end

    run_phase(CW'(5), 0, 120);
    run_phase(CW'(DEPTH), 27, 340);
    run_phase(CW'($urandom_range(40, 1)), 66, 180);
    run_phase(CW'(17), 27, 150);
    run_phase(CW'(2), 66, 160);

    wait_idle();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_ctrl.sv
rtl/tss_dpath.sv
rtl/two_stacks_shared_memory.sv
verif/tb_two_stacks_shared_memory.sv
